// ===== sv/ising_metropolis_site_update_unit_defines.svh =====
// Assertion macros shared by the site update unit.
// Included by the modules that check their own control logic; no dependencies.
`ifndef ISING_METROPOLIS_SITE_UPDATE_UNIT_DEFINES_SVH
`define ISING_METROPOLIS_SITE_UPDATE_UNIT_DEFINES_SVH

// Implication checked in the same cycle as the antecedent.
`define IMSU_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("imsu: same-cycle check failed");

// Implication checked in the cycle after the antecedent.
`define IMSU_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("imsu: next-cycle check failed");

`endif

// ===== sv/imsu_pkg.sv =====
// Types and constants of the Ising site update unit.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package imsu_pkg;

  // Field widths of the request and result channels.
  localparam int COORD_W     = 6;
  localparam int COORD_COUNT = 64;
  localparam int RAND_W      = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int ENTRY_W     = 17;
  localparam int PARAM_W     = 5;
  localparam int DE_W        = 8;

  // Acceptance table layout: spin bit selects a row of five neighbour counts.
  localparam int ENTRY_COUNT  = 10;
  localparam int ENTRY_STRIDE = 5;
  localparam int NBR_W        = 3;

  // The reported energy change is clipped to this magnitude.
  localparam int DE_LIMIT = 80;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic signed [PARAM_W-1:0] COUPLING_RESET = 5'sd1;
  localparam logic signed [PARAM_W-1:0] FIELD_RESET    = 5'sd0;

  typedef enum logic {
    REG_COUPLING = 1'b0,
    REG_FIELD    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_STEP        = 2'd0,
    OP_WRITE_SPIN  = 2'd1,
    OP_READ_SPIN   = 2'd2,
    OP_WRITE_ENTRY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/imsu_ifs.sv =====
// Request and result channel interfaces of the Ising site update unit.
// Depends on imsu_pkg for the field widths.
`default_nettype none

interface imsu_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [imsu_pkg::COORD_W-1:0]        row;
  logic [imsu_pkg::COORD_W-1:0]        col;
  logic [imsu_pkg::RAND_W-1:0]         random_fraction;
  logic                                spin_in;
  logic [imsu_pkg::ENTRY_IDX_W-1:0]    entry_index;
  logic [imsu_pkg::ENTRY_W-1:0]        entry_value;

  modport source (
    output valid, op, row, col, random_fraction, spin_in, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, op, row, col, random_fraction, spin_in, entry_index, entry_value,
    output ready
  );
endinterface

interface imsu_res_if;
  logic                              valid;
  logic                              ready;
  logic                              flipped;
  logic signed [imsu_pkg::DE_W-1:0]  energy_change;
  logic                              spin_out;

  modport source (
    output valid, flipped, energy_change, spin_out,
    input  ready
  );
  modport sink (
    input  valid, flipped, energy_change, spin_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ising_metropolis_site_update_unit.sv =====
// Ising site update unit: single-site Metropolis updates on a periodic square lattice.
//
// Requests arrive on a valid/ready channel (op, row, col, random_fraction, spin_in,
// entry_index, entry_value). Op step proposes flipping the addressed spin and returns
// whether it flipped, the energy change 2*s*(J*sum+h) clipped to +/-80, and the new
// spin. Op write spin and op read spin set or return a spin; op write entry loads one
// Q1.16 acceptance threshold. Every request gives exactly one result on the result
// channel, in order.
// Each request is captured, then reads its site and four neighbours from three copies of the
// lattice memory in the read state, then is evaluated and written back in the evaluation
// state and retired into the result register. A new request is accepted during the
// evaluation of the last one when the result side keeps up.
// A finished result waits in an output register; the next request is accepted and
// read meanwhile, and the unit holds in evaluation while the receiver stalls.
// Reset sets coupling to 1 and field to 0 and empties the result register. Lattice and
// threshold contents are undefined until written; there is no clearing pass. The user must
// write coupling and field over the APB-style port only while idle; the unit does not enforce it.
`default_nettype none

module ising_metropolis_site_update_unit #(
  parameter int SIDE = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [imsu_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [imsu_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [imsu_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  imsu_req_if.sink                               request,
  imsu_res_if.source                             result
);

  logic signed [imsu_pkg::PARAM_W-1:0] coupling;
  logic signed [imsu_pkg::PARAM_W-1:0] external_field;
  imsu_pkg::dp_cmd_t                   cmd;

  // Configuration registers.
  imsu_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .coupling       (coupling),
    .external_field (external_field)
  );

  // Sequencing and handshakes.
  imsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // Lattice, thresholds and arithmetic.
  imsu_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .op              (request.op),
    .row             (request.row),
    .col             (request.col),
    .random_fraction (request.random_fraction),
    .spin_in         (request.spin_in),
    .entry_index     (request.entry_index),
    .entry_value     (request.entry_value),
    .coupling        (coupling),
    .external_field  (external_field),
    .flipped         (result.flipped),
    .energy_change   (result.energy_change),
    .spin_out        (result.spin_out)
  );

endmodule

`default_nettype wire

// ===== sv/imsu_cfg.sv =====
// Configuration registers (coupling and external field) behind an APB-style port.
// Depends on imsu_pkg for widths, register codes and reset values.
`default_nettype none

module imsu_cfg (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [imsu_pkg::APB_ADDR_W-1:0]        paddr,
  input  wire logic [imsu_pkg::APB_DATA_W-1:0]        pwdata,
  output logic      [imsu_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                        pready,
  output logic signed [imsu_pkg::PARAM_W-1:0]         coupling,
  output logic signed [imsu_pkg::PARAM_W-1:0]         external_field
);

  imsu_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  // The word address bit picks the register.
  assign reg_sel = imsu_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes take the low bits of the data as a signed value.
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling       <= imsu_pkg::COUPLING_RESET;
      external_field <= imsu_pkg::FIELD_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        imsu_pkg::REG_COUPLING: coupling       <= $signed(pwdata[imsu_pkg::PARAM_W-1:0]);
        imsu_pkg::REG_FIELD:    external_field <= $signed(pwdata[imsu_pkg::PARAM_W-1:0]);
        default: ;
      endcase
    end
  end

  // Reads return the register sign-extended to the bus width.
  always_comb begin
    case (reg_sel)
      imsu_pkg::REG_COUPLING: prdata = imsu_pkg::APB_DATA_W'(coupling);
      imsu_pkg::REG_FIELD:    prdata = imsu_pkg::APB_DATA_W'(external_field);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/imsu_ctrl.sv =====
// Controller of the Ising site update unit: request/result handshakes and sequencing.
// Depends on imsu_pkg and the assertion macros header.
`default_nettype none
`include "ising_metropolis_site_update_unit_defines.svh"

module imsu_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output imsu_pkg::dp_cmd_t  cmd
);

  imsu_pkg::state_t state;
  imsu_pkg::state_t state_next;
  logic             out_valid_next;
  logic             can_retire;
  logic             accept;

  // The result register can take a new result when empty or being drained.
  assign can_retire = !out_valid || out_ready;

  // Output and handshake decode.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.read    = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      imsu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      imsu_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      imsu_pkg::ST_EVAL: begin
        in_ready   = can_retire;
        cmd.commit = can_retire;
      end
      default: ;
    endcase
    accept      = in_valid && in_ready;
    cmd.capture = accept;
  end

  // Next state: a request is read, evaluated, then retired into the result register.
  always_comb begin
    state_next = state;
    case (state)
      imsu_pkg::ST_IDLE: begin
        if (accept) state_next = imsu_pkg::ST_READ;
      end
      imsu_pkg::ST_READ: begin
        state_next = imsu_pkg::ST_EVAL;
      end
      imsu_pkg::ST_EVAL: begin
        if (can_retire) state_next = accept ? imsu_pkg::ST_READ : imsu_pkg::ST_IDLE;
      end
      default: state_next = imsu_pkg::ST_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imsu_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `IMSU_ASSERT_NEXT(a_read_then_eval, clk, rst, state == imsu_pkg::ST_READ, state == imsu_pkg::ST_EVAL)
  `IMSU_ASSERT_NEXT(a_accept_starts_read, clk, rst, in_valid && in_ready, state == imsu_pkg::ST_READ)
  `IMSU_ASSERT_NOW(a_result_from_eval, clk, rst, $rose(out_valid), $past(state) == imsu_pkg::ST_EVAL)

endmodule

`default_nettype wire

// ===== sv/imsu_datapath.sv =====
// Datapath of the Ising site update unit: lattice copies, acceptance table,
// energy change and accept decision, result register. Depends on imsu_pkg.
`default_nettype none

module imsu_datapath #(
  parameter int SIDE = 64
) (
  input  wire logic                                  clk,
  input  wire imsu_pkg::dp_cmd_t                     cmd,
  input  wire logic [1:0]                            op,
  input  wire logic [imsu_pkg::COORD_W-1:0]          row,
  input  wire logic [imsu_pkg::COORD_W-1:0]          col,
  input  wire logic [imsu_pkg::RAND_W-1:0]           random_fraction,
  input  wire logic                                  spin_in,
  input  wire logic [imsu_pkg::ENTRY_IDX_W-1:0]      entry_index,
  input  wire logic [imsu_pkg::ENTRY_W-1:0]          entry_value,
  input  wire logic signed [imsu_pkg::PARAM_W-1:0]   coupling,
  input  wire logic signed [imsu_pkg::PARAM_W-1:0]   external_field,
  output logic                                       flipped,
  output logic signed [imsu_pkg::DE_W-1:0]           energy_change,
  output logic                                       spin_out
);

  localparam int IDX_W  = $clog2(SIDE);
  localparam int DEPTH  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EW     = imsu_pkg::ENTRY_IDX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SIDE - 1);
  localparam logic signed [10:0] DE_HI = 11'(imsu_pkg::DE_LIMIT);
  localparam logic signed [10:0] DE_LO = -DE_HI;

  // Coordinates reduced modulo the lattice side, worked out at elaboration.
  logic [IDX_W-1:0] coord_mod [imsu_pkg::COORD_COUNT];
  for (genvar g = 0; g < imsu_pkg::COORD_COUNT; g++) begin : g_mod
    assign coord_mod[g] = IDX_W'(g % SIDE);
  end

  imsu_pkg::op_t                   op_q;
  logic [IDX_W-1:0]                row_q;
  logic [IDX_W-1:0]                col_q;
  logic [imsu_pkg::RAND_W-1:0]     rnd_q;
  logic                            spin_in_q;
  logic [EW-1:0]                   eidx_q;
  logic [imsu_pkg::ENTRY_W-1:0]    evalue_q;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= imsu_pkg::op_t'(op);
      row_q     <= coord_mod[row];
      col_q     <= coord_mod[col];
      rnd_q     <= random_fraction;
      spin_in_q <= spin_in;
      eidx_q    <= entry_index;
      evalue_q  <= entry_value;
    end
  end

  function automatic logic [ADDR_W-1:0] site_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    site_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c));
  endfunction

  // Neighbour coordinates with wrap-around.
  logic [IDX_W-1:0]  row_up, row_dn, col_lf, col_rt;
  logic [ADDR_W-1:0] addr_c, addr_l, addr_r, addr_u, addr_d;

  always_comb begin
    row_up = (row_q == '0)  ? LAST : row_q - IDX_W'(1);
    row_dn = (row_q == LAST) ? '0  : row_q + IDX_W'(1);
    col_lf = (col_q == '0)  ? LAST : col_q - IDX_W'(1);
    col_rt = (col_q == LAST) ? '0  : col_q + IDX_W'(1);
    addr_c = site_addr(row_q, col_q);
    addr_l = site_addr(row_q, col_lf);
    addr_r = site_addr(row_q, col_rt);
    addr_u = site_addr(row_up, col_q);
    addr_d = site_addr(row_dn, col_q);
  end

  // Three identical lattice copies give five reads in the same cycle.
  logic mem_a [DEPTH];
  logic mem_b [DEPTH];
  logic mem_c [DEPTH];
  logic center_q, left_q, right_q, up_q, down_q;
  logic lat_we, lat_wdata;

  always_ff @(posedge clk) begin
    if (lat_we) mem_a[addr_c] <= lat_wdata;
    if (cmd.read) begin
      center_q <= mem_a[addr_c];
      left_q   <= mem_a[addr_l];
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) mem_b[addr_c] <= lat_wdata;
    if (cmd.read) begin
      right_q <= mem_b[addr_r];
      up_q    <= mem_b[addr_u];
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) mem_c[addr_c] <= lat_wdata;
    if (cmd.read) down_q <= mem_c[addr_d];
  end

  // Acceptance thresholds, loaded by request.
  logic [imsu_pkg::ENTRY_W-1:0] accept_tab [imsu_pkg::ENTRY_COUNT];

  always_ff @(posedge clk) begin
    if (cmd.commit && op_q == imsu_pkg::OP_WRITE_ENTRY &&
        eidx_q < EW'(imsu_pkg::ENTRY_COUNT)) begin
      accept_tab[eidx_q] <= evalue_q;
    end
  end

  // Energy change of flipping the centre spin and the Metropolis decision.
  logic [imsu_pkg::NBR_W-1:0]      up_count;
  logic signed [4:0]               nbr_sum;
  logic signed [9:0]               coupled;
  logic signed [9:0]               local_field;
  logic signed [10:0]              de;
  logic                            de_pos;
  logic [EW-1:0]                   entry_sel;
  logic [imsu_pkg::ENTRY_W-1:0]    threshold;
  logic                            accept;
  logic signed [imsu_pkg::DE_W-1:0] de_sat;

  always_comb begin
    up_count    = imsu_pkg::NBR_W'(left_q) + imsu_pkg::NBR_W'(right_q)
                + imsu_pkg::NBR_W'(up_q) + imsu_pkg::NBR_W'(down_q);
    nbr_sum     = $signed({1'b0, up_count, 1'b0}) - 5'sd4;
    coupled     = coupling * nbr_sum;
    local_field = coupled + 10'(external_field);
    de          = center_q ? $signed({local_field, 1'b0}) : -$signed({local_field, 1'b0});
    de_pos      = de > 11'sd0;
    entry_sel   = center_q ? EW'(imsu_pkg::ENTRY_STRIDE) + EW'(up_count) : EW'(up_count);
    threshold   = accept_tab[entry_sel];
    accept      = !de_pos || (imsu_pkg::ENTRY_W'(rnd_q) <= threshold);
    if (de > DE_HI) begin
      de_sat = imsu_pkg::DE_W'(DE_HI);
    end else if (de < DE_LO) begin
      de_sat = imsu_pkg::DE_W'(DE_LO);
    end else begin
      de_sat = de[imsu_pkg::DE_W-1:0];
    end
  end

  // Lattice write for a flip or a spin write.
  always_comb begin
    lat_we    = 1'b0;
    lat_wdata = 1'b0;
    case (op_q)
      imsu_pkg::OP_STEP: begin
        lat_we    = cmd.commit && accept;
        lat_wdata = !center_q;
      end
      imsu_pkg::OP_WRITE_SPIN: begin
        lat_we    = cmd.commit;
        lat_wdata = spin_in_q;
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (op_q)
        imsu_pkg::OP_STEP: begin
          flipped       <= accept;
          energy_change <= de_sat;
          spin_out      <= center_q ^ accept;
        end
        imsu_pkg::OP_WRITE_SPIN: begin
          flipped       <= 1'b0;
          energy_change <= '0;
          spin_out      <= spin_in_q;
        end
        imsu_pkg::OP_READ_SPIN: begin
          flipped       <= 1'b0;
          energy_change <= '0;
          spin_out      <= center_q;
        end
        default: begin
          flipped       <= 1'b0;
          energy_change <= '0;
          spin_out      <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
